// ===== design/message_length_padder_core_assert.svh =====
// Assertion macros shared by the padder RTL
`ifndef MESSAGE_LENGTH_PADDER_CORE_ASSERT_SVH
`define MESSAGE_LENGTH_PADDER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define MLP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset
`define MLP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/mlp_pkg.sv =====
// Package with constants for the message length padder
`timescale 1ns / 1ps
`default_nettype none
package mlp_pkg;

  localparam int BLOCK_BYTES_DEF = 16;
  localparam int LEN_BYTES       = 8;
  localparam int COUNT_W         = 64;
  localparam logic [7:0] PAD_MARK = 8'h80;

endpackage
`default_nettype wire

// ===== design/message_length_padder_core.sv =====
// Top level of the message length padder: pass-through counter and padding sequencer
//
//   channel  | dir | tdata         | tuser   | tlast
//   s_axis   | in  | data_byte[7:0]| is_end  | -
//   m_axis   | out | out_byte[7:0] | -       | last_of_message
//
// A new data request is taken each cycle while the output register is free
// or being drained. An end request emits the
// padding at one byte per cycle: r bytes, or r + BLOCK_BYTES when r < 9,
// where r = BLOCK_BYTES - (count mod BLOCK_BYTES); the padding sequencer
// holds s_axis_tready low until its final byte is loaded. Output stalls
// freeze the sequencer. Reset is synchronous and clears the count at once.
`timescale 1ns / 1ps
`default_nettype none
`include "message_length_padder_core_assert.svh"
module message_length_padder_core #(
  parameter int BLOCK_BYTES = mlp_pkg::BLOCK_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  wire logic       s_axis_tuser,   // [0] is_end
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic            m_axis_tlast
);
  import mlp_pkg::*;

  localparam int BPW = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
  localparam int PW  = $clog2(BLOCK_BYTES + LEN_BYTES + 1);

  logic [COUNT_W-1:0] byte_count;
  logic [BPW-1:0]     blk_pos;
  logic               pad_active;
  logic [PW-1:0]      pad_idx;
  logic [PW-1:0]      pad_len;
  logic [PW-1:0]      len_start;
  logic [COUNT_W-1:0] len_val;

  logic               out_free;
  logic               in_take;
  logic [PW-1:0]      rem;
  logic [PW-1:0]      pad_len_calc;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !pad_active && out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Bytes left in the current block, then padding length
  assign rem          = PW'(BLOCK_BYTES) - PW'(blk_pos);
  assign pad_len_calc = (rem < PW'(LEN_BYTES + 1)) ? rem + PW'(BLOCK_BYTES) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      blk_pos       <= '0;
      pad_active    <= 1'b0;
      pad_idx       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (in_take || (pad_active && out_free)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (in_take) begin
        if (!s_axis_tuser) begin
          m_axis_tdata <= s_axis_tdata;
          m_axis_tlast <= 1'b0;
          byte_count   <= byte_count + COUNT_W'(1);
          blk_pos      <= (blk_pos == BPW'(BLOCK_BYTES - 1)) ? '0 : blk_pos + BPW'(1);
        end else begin
          // Emit the marker now, sequence the rest
          m_axis_tdata <= PAD_MARK;
          m_axis_tlast <= 1'b0;
          len_val      <= byte_count;
          pad_len      <= pad_len_calc;
          len_start    <= pad_len_calc - PW'(LEN_BYTES);
          pad_idx      <= PW'(1);
          pad_active   <= 1'b1;
          byte_count   <= '0;
          blk_pos      <= '0;
        end
      end else if (pad_active && out_free) begin
        if (pad_idx < len_start) begin
          m_axis_tdata <= 8'h00;
        end else begin
          // Length goes out big-endian: take the top byte, shift up
          m_axis_tdata <= len_val[COUNT_W-1 -: 8];
          len_val      <= {len_val[COUNT_W-9:0], 8'h00};
        end
        m_axis_tlast <= (pad_idx == pad_len - PW'(1));
        if (pad_idx == pad_len - PW'(1)) begin
          pad_active <= 1'b0;
        end
        pad_idx <= pad_idx + PW'(1);
      end
    end
  end

  `MLP_ASSERT_SAME(a_no_req_in_pad, pad_active, !s_axis_tready)
  `MLP_ASSERT_NEXT(a_end_marks, in_take && s_axis_tuser,
                   pad_active && m_axis_tvalid && m_axis_tdata == PAD_MARK && !m_axis_tlast)
  `MLP_ASSERT_SAME(a_last_ends_pad, m_axis_tvalid && m_axis_tlast, !pad_active)
  `MLP_ASSERT_NEXT(a_pad_clears_count, in_take && s_axis_tuser,
                   byte_count == '0 && blk_pos == '0)

endmodule
`default_nettype wire
